/* rtl/ace_pkg.sv */
// Package for the color equalization core: payload and status types, register
// indexes, state and command codes, fixed-point widths.
// No dependencies; compiled first.
package ace_pkg;

    // Defaults for the top-level size parameters
    localparam int MAX_WIDTH_DEF   = 256;
    localparam int MAX_HEIGHT_DEF  = 256;
    localparam int MAX_SAMPLES_DEF = 256;

    localparam int NCHAN     = 3;
    localparam int DIM_W     = 9;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int SCORE_W   = 32;
    localparam int NUM_W     = 48;
    localparam int DIV_W     = 64;
    localparam int Q_SH      = 16;
    localparam int D2_W      = 20;
    localparam int ROOT_W    = 37;
    localparam int DQ_W      = 19;
    localparam int ROOT_STEPS = 18;
    localparam int ROOT_BIT0  = 34;
    localparam int PROD_W    = 27;
    localparam int T_W       = 7;
    localparam int T2_W      = 14;
    // floor(h/5) as (h*205)>>10, exact for 9-bit h
    localparam int DIV5_MUL  = 205;
    localparam int DIV5_SH   = 10;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd4;

    typedef enum logic [1:0] {
        KIND_LD_SMP  = 2'd0,
        KIND_LD_PIX  = 2'd1,
        KIND_COMPUTE = 2'd2,
        KIND_READ    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] coord_x;
        logic [7:0] coord_y;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       is_done;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE, S_C_PIX, S_C_PIXW, S_C_SMP, S_C_SMPW, S_C_GEO, S_C_TEST,
        S_C_ROOT, S_C_MUL, S_C_DIVN, S_C_DIVNW, S_C_DIVD, S_C_DIVDW,
        S_C_FDIV, S_C_FDIVW, S_C_FNEXT, S_C_WR, S_C_OUT,
        S_R_DIV, S_R_DIVW, S_R_NEXT, S_R_OUT
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LD_SMP, CMD_LD_PIX, CMD_CMP_INIT, CMD_RD_INIT,
        CMD_PIX_RD, CMD_PIX_CAP, CMD_SMP_RD, CMD_SMP_CAP, CMD_GEO, CMD_SKIP,
        CMD_ROOT_GO, CMD_MUL, CMD_NUM_GO, CMD_NUM_ACC, CMD_DEN_GO, CMD_DEN_ACC,
        CMD_FIN_GO, CMD_FIN_ACC, CMD_FIN_UPD, CMD_SC_WR,
        CMD_RD_GO, CMD_RD_ACC, CMD_RD_NEXT, CMD_OUT_DONE, CMD_OUT_PIX
    } t_cmd;

    typedef struct packed {
        logic dims_zero;
        logic s_end;
        logic skip;
        logic root_done;
        logic div_done;
        logic c_last;
        logic fin_zero;
        logic rd_zero;
        logic j_last;
        logic i_last;
        logic out_free;
    } t_stat;

endpackage

/* rtl/ace_div.sv */
// Serial signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on ace_pkg.
module ace_div
    import ace_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [DIV_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W:0]   r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_den;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   sh;
    logic             fit;

    // shift in the next dividend bit and test the divisor
    assign sh  = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
    assign fit = sh >= {1'b0, r_den};

    // control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(DIV_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath: magnitudes and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[DIV_W-1];
            r_quo <= i_num[DIV_W-1] ? DIV_W'(-i_num) : DIV_W'(i_num);
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fit ? (sh - {1'b0, r_den}) : sh;
            r_quo <= {r_quo[DIV_W-2:0], fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

/* rtl/ace_root.sv */
// Digit-by-digit square root of a squared distance, giving Q11.8 distance.
// Depends on ace_pkg.
module ace_root
    import ace_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [D2_W-1:0] i_d2,
    output logic            o_done,
    output logic [DQ_W-1:0] o_res
);

    logic [ROOT_W-1:0] r_v;
    logic [ROOT_W-1:0] r_res;
    logic [ROOT_W-1:0] r_bit;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ROOT_W-1:0] trial;

    assign trial = r_res + r_bit;

    // control: step count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 5'(ROOT_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'(ROOT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // one root digit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= ROOT_W'(i_d2) << Q_SH;
            r_res <= '0;
            r_bit <= ROOT_W'(1) << ROOT_BIT0;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res[DQ_W-1:0];

endmodule

/* rtl/ace_dp.sv */
// Datapath: configuration, frame/score/sample memories, accumulators,
// channel extremes and output register. Depends on ace_pkg, ace_div, ace_root.
module ace_dp
    import ace_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in                  i_in,
    input  t_cmd                 i_cmd,
    input  logic                 i_out_stall,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    output t_out                 o_out
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    function automatic logic [AW-1:0] pix_addr(input logic [DIM_W-1:0] x,
                                               input logic [DIM_W-1:0] y);
        return AW'(AW'(y) * AW'(MAX_WIDTH) + AW'(x));
    endfunction

    // configuration
    logic [DIM_W-1:0] r_w_cfg, r_h_cfg, r_n_cfg;
    logic [15:0]      r_slope;
    logic [23:0]      r_limit;
    logic [DIM_W-1:0] w_eff, h_eff, n_eff;
    logic [T_W-1:0]   r_t;
    logic [T2_W-1:0]  r_t2;

    // memories
    logic [23:0]              frame_mem [DEPTH];
    logic [NCHAN*SCORE_W-1:0] score_mem [DEPTH];
    logic [15:0]              sample_mem [MAX_SAMPLES];
    logic [23:0]              r_frd;
    logic [NCHAN*SCORE_W-1:0] r_scrd;
    logic [15:0]              r_smp_rd;

    // loop state
    logic [SW-1:0]    r_ptr;
    logic [DIM_W-1:0] r_i, r_j, r_s;
    logic [1:0]       r_c, n_c;
    logic             c_last;

    // working values
    logic [23:0]                r_pix;
    logic [DIM_W-1:0]           r_sx, r_sy;
    logic [D2_W-1:0]            r_d2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [NUM_W-1:0]    r_num [NCHAN];
    logic [NUM_W-1:0]           r_den;
    logic signed [SCORE_W-1:0]  r_sc  [NCHAN];
    logic signed [SCORE_W-1:0]  r_max [NCHAN];
    logic signed [SCORE_W-1:0]  r_min [NCHAN];
    logic [7:0]                 r_ob  [NCHAN];
    logic                       r_inside;
    t_out                       r_out;
    logic                       r_out_vld;

    logic                     in_inside;
    logic                     out_free;
    logic                     frd_en;
    logic [AW-1:0]            frd_addr;
    logic [DIM_W-1:0]         smp_x, smp_y;
    logic signed [DIM_W:0]    dx, dy;
    logic signed [DIM_W:0]    diff;
    logic signed [PROD_W-1:0] lim_s, p_clamp;
    logic signed [SCORE_W-1:0] rd_v;
    logic signed [SCORE_W:0]  rd_off, rd_rng;
    logic [DIV_W-1:0]         rd_off_w;
    logic                     div_go;
    logic signed [DIV_W-1:0]  div_num;
    logic [DIV_W-1:0]         div_den;
    logic                     div_done;
    logic signed [DIV_W-1:0]  div_q;
    logic                     root_done;
    logic [DQ_W-1:0]          root_res;

    // effective sizes
    assign w_eff = (32'(r_w_cfg) > MAX_WIDTH)   ? DIM_W'(MAX_WIDTH)   : r_w_cfg;
    assign h_eff = (32'(r_h_cfg) > MAX_HEIGHT)  ? DIM_W'(MAX_HEIGHT)  : r_h_cfg;
    assign n_eff = (32'(r_n_cfg) > MAX_SAMPLES) ? DIM_W'(MAX_SAMPLES) : r_n_cfg;

    assign in_inside = (32'(i_in.coord_x) < MAX_WIDTH) && (32'(i_in.coord_y) < MAX_HEIGHT);
    assign out_free  = !r_out_vld || !i_out_stall;
    assign c_last    = (r_c == 2'(NCHAN - 1));
    assign n_c       = c_last ? 2'd0 : r_c + 2'd1;

    // sample position saturated to the active frame
    assign smp_x = (9'(r_smp_rd[7:0])  > w_eff - 1'b1) ? w_eff - 1'b1 : 9'(r_smp_rd[7:0]);
    assign smp_y = (9'(r_smp_rd[15:8]) > h_eff - 1'b1) ? h_eff - 1'b1 : 9'(r_smp_rd[15:8]);

    assign dx = $signed({1'b0, r_i}) - $signed({1'b0, r_sx});
    assign dy = $signed({1'b0, r_j}) - $signed({1'b0, r_sy});

    assign diff = $signed({2'b0, r_pix[8*r_c +: 8]}) - $signed({2'b0, r_frd[8*r_c +: 8]});

    // saturate the weighted difference
    assign lim_s   = $signed({3'b0, r_limit});
    assign p_clamp = (r_prod > lim_s) ? lim_s : ((r_prod < -lim_s) ? -lim_s : r_prod);

    // readout offset and range
    assign rd_v     = $signed(r_scrd[SCORE_W*r_c +: SCORE_W]);
    assign rd_off   = SCORE_W'(1) == 0 ? '0 : ($signed({rd_v[SCORE_W-1], rd_v})
                      - $signed({r_min[r_c][SCORE_W-1], r_min[r_c]}));
    assign rd_rng   = $signed({r_max[r_c][SCORE_W-1], r_max[r_c]})
                      - $signed({r_min[r_c][SCORE_W-1], r_min[r_c]});
    assign rd_off_w = DIV_W'(unsigned'(rd_off));

    // divider operand select
    always_comb begin
        div_go  = 1'b0;
        div_num = '0;
        div_den = DIV_W'(root_res);
        case (i_cmd)
            CMD_NUM_GO: begin
                div_go  = 1'b1;
                div_num = {{(DIV_W-PROD_W-Q_SH){p_clamp[PROD_W-1]}}, p_clamp, 16'b0};
            end
            CMD_DEN_GO: begin
                div_go  = 1'b1;
                div_num = $signed({{(DIV_W-24-Q_SH){1'b0}}, r_limit, 16'b0});
            end
            CMD_FIN_GO: begin
                div_go  = (r_den != '0);
                div_num = {r_num[r_c], 16'b0};
                div_den = DIV_W'(r_den);
            end
            CMD_RD_GO: begin
                div_go  = !o_stat.rd_zero;
                div_num = $signed((rd_off_w << 8) - rd_off_w);
                div_den = DIV_W'(unsigned'(rd_rng));
            end
            default: ;
        endcase
    end

    ace_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    ace_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd == CMD_ROOT_GO),
        .i_d2    (r_d2),
        .o_done  (root_done),
        .o_res   (root_res)
    );

    // frame store: load port and one read port
    assign frd_en   = (i_cmd == CMD_PIX_RD) || (i_cmd == CMD_GEO);
    assign frd_addr = (i_cmd == CMD_GEO) ? pix_addr(r_sx, r_sy) : pix_addr(r_i, r_j);

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_LD_PIX && in_inside) begin
            frame_mem[pix_addr(9'(i_in.coord_x), 9'(i_in.coord_y))] <=
                {i_in.blue_in, i_in.green_in, i_in.red_in};
        end
        if (frd_en) begin
            r_frd <= frame_mem[frd_addr];
        end
    end

    // score store
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_SC_WR) begin
            score_mem[pix_addr(r_i, r_j)] <= {r_sc[2], r_sc[1], r_sc[0]};
        end
        if (i_cmd == CMD_RD_INIT) begin
            r_scrd <= score_mem[in_inside ? pix_addr(9'(i_in.coord_x), 9'(i_in.coord_y))
                                          : AW'(0)];
        end
    end

    // sample store
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_LD_SMP) begin
            sample_mem[r_ptr] <= {i_in.coord_y, i_in.coord_x};
        end
        if (i_cmd == CMD_SMP_RD) begin
            r_smp_rd <= sample_mem[SW'(r_s)];
        end
    end

    // control registers: configuration, counters, extremes, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_cfg   <= 9'd256;
            r_h_cfg   <= 9'd256;
            r_n_cfg   <= 9'd64;
            r_slope   <= 16'd2560;
            r_limit   <= 24'd256000;
            r_ptr     <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_s       <= '0;
            r_c       <= '0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < NCHAN; k++) begin
                r_max[k] <= '0;
                r_min[k] <= SCORE_MAX;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:   r_w_cfg <= i_cfg_data[DIM_W-1:0];
                    REG_HEIGHT:  r_h_cfg <= i_cfg_data[DIM_W-1:0];
                    REG_SAMPLES: r_n_cfg <= i_cfg_data[DIM_W-1:0];
                    REG_SLOPE:   r_slope <= i_cfg_data[15:0];
                    REG_LIMIT:   r_limit <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            // raise valid on a new output beat, drop it once taken
            if ((i_cmd == CMD_OUT_DONE || i_cmd == CMD_OUT_PIX) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (i_cmd)
                CMD_LD_SMP: begin
                    r_ptr <= (r_ptr == SW'(MAX_SAMPLES - 1)) ? '0 : r_ptr + 1'b1;
                end
                CMD_CMP_INIT: begin
                    r_ptr <= '0;
                    r_i   <= '0;
                    r_j   <= '0;
                    for (int k = 0; k < NCHAN; k++) begin
                        r_max[k] <= '0;
                        r_min[k] <= SCORE_MAX;
                    end
                end
                CMD_RD_INIT: r_c <= '0;
                CMD_PIX_RD: begin
                    r_s <= '0;
                    r_c <= '0;
                end
                CMD_SKIP, CMD_DEN_ACC: r_s <= r_s + 1'b1;
                CMD_NUM_ACC, CMD_RD_NEXT: r_c <= n_c;
                CMD_FIN_UPD: begin
                    if (r_sc[r_c] > r_max[r_c]) r_max[r_c] <= r_sc[r_c];
                    if (r_sc[r_c] < r_min[r_c]) r_min[r_c] <= r_sc[r_c];
                    r_c <= n_c;
                end
                CMD_SC_WR: begin
                    if (o_stat.j_last) begin
                        r_j <= '0;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_t  <= T_W'((18'(h_eff) * 18'(DIV5_MUL)) >> DIV5_SH);
        r_t2 <= T2_W'(r_t * r_t);
        case (i_cmd)
            CMD_RD_INIT: r_inside <= in_inside;
            CMD_PIX_RD: begin
                r_den <= '0;
                for (int k = 0; k < NCHAN; k++) r_num[k] <= '0;
            end
            CMD_PIX_CAP: r_pix <= r_frd;
            CMD_SMP_CAP: begin
                r_sx <= smp_x;
                r_sy <= smp_y;
            end
            CMD_GEO:     r_d2 <= D2_W'(dx * dx) + D2_W'(dy * dy);
            CMD_MUL:     r_prod <= diff * $signed({1'b0, r_slope});
            CMD_NUM_ACC: r_num[r_c] <= r_num[r_c] + NUM_W'(div_q);
            CMD_DEN_ACC: r_den <= r_den + NUM_W'(div_q);
            CMD_FIN_GO:  if (r_den == '0) r_sc[r_c] <= '0;
            CMD_FIN_ACC: begin
                if (div_q > DIV_W'(SCORE_MAX))      r_sc[r_c] <= SCORE_MAX;
                else if (div_q < DIV_W'(SCORE_MIN)) r_sc[r_c] <= SCORE_MIN;
                else                                r_sc[r_c] <= SCORE_W'(div_q);
            end
            CMD_RD_GO:   if (o_stat.rd_zero) r_ob[r_c] <= '0;
            CMD_RD_ACC:  r_ob[r_c] <= (div_q > 64'sd255) ? 8'd255 : div_q[7:0];
            CMD_OUT_DONE: if (out_free) r_out <= '{8'd0, 8'd0, 8'd0, 1'b1};
            CMD_OUT_PIX:  if (out_free) r_out <= '{r_ob[0], r_ob[1], r_ob[2], 1'b0};
            default: ;
        endcase
    end

    // status to the controller
    always_comb begin
        o_stat.dims_zero = (w_eff == '0) || (h_eff == '0);
        o_stat.s_end     = (r_s == n_eff);
        o_stat.skip      = (r_d2 < D2_W'(r_t2)) || (r_d2 == '0);
        o_stat.root_done = root_done;
        o_stat.div_done  = div_done;
        o_stat.c_last    = c_last;
        o_stat.fin_zero  = (r_den == '0);
        o_stat.rd_zero   = !r_inside || !(r_max[r_c] > r_min[r_c]) || !(rd_off > 0);
        o_stat.j_last    = (r_j == h_eff - 1'b1);
        o_stat.i_last    = (r_i == w_eff - 1'b1);
        o_stat.out_free  = out_free;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

/* rtl/ace_ctrl.sv */
// Controller state machine: sequences loads, the per-pixel/per-sample
// compute loop and the readout. Depends on ace_pkg.
module ace_ctrl
    import ace_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_kind i_kind,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_COMPUTE: n_state = i_stat.dims_zero ? S_C_OUT : S_C_PIX;
                        KIND_READ:    n_state = S_R_DIV;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_C_PIX:   n_state = S_C_PIXW;
            S_C_PIXW:  n_state = S_C_SMP;
            S_C_SMP:   n_state = i_stat.s_end ? S_C_FDIV : S_C_SMPW;
            S_C_SMPW:  n_state = S_C_GEO;
            S_C_GEO:   n_state = S_C_TEST;
            S_C_TEST:  n_state = i_stat.skip ? S_C_SMP : S_C_ROOT;
            S_C_ROOT:  if (i_stat.root_done) n_state = S_C_MUL;
            S_C_MUL:   n_state = S_C_DIVN;
            S_C_DIVN:  n_state = S_C_DIVNW;
            S_C_DIVNW: if (i_stat.div_done) n_state = i_stat.c_last ? S_C_DIVD : S_C_MUL;
            S_C_DIVD:  n_state = S_C_DIVDW;
            S_C_DIVDW: if (i_stat.div_done) n_state = S_C_SMP;
            S_C_FDIV:  n_state = i_stat.fin_zero ? S_C_FNEXT : S_C_FDIVW;
            S_C_FDIVW: if (i_stat.div_done) n_state = S_C_FNEXT;
            S_C_FNEXT: n_state = i_stat.c_last ? S_C_WR : S_C_FDIV;
            S_C_WR:    n_state = (i_stat.j_last && i_stat.i_last) ? S_C_OUT : S_C_PIX;
            S_C_OUT:   if (i_stat.out_free) n_state = S_IDLE;
            S_R_DIV:   n_state = i_stat.rd_zero ? S_R_NEXT : S_R_DIVW;
            S_R_DIVW:  if (i_stat.div_done) n_state = S_R_NEXT;
            S_R_NEXT:  n_state = i_stat.c_last ? S_R_OUT : S_R_DIV;
            S_R_OUT:   if (i_stat.out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_LD_SMP:  o_cmd = CMD_LD_SMP;
                        KIND_LD_PIX:  o_cmd = CMD_LD_PIX;
                        KIND_COMPUTE: o_cmd = CMD_CMP_INIT;
                        KIND_READ:    o_cmd = CMD_RD_INIT;
                        default:      o_cmd = CMD_NONE;
                    endcase
                end
            end
            S_C_PIX:   o_cmd = CMD_PIX_RD;
            S_C_PIXW:  o_cmd = CMD_PIX_CAP;
            S_C_SMP:   o_cmd = i_stat.s_end ? CMD_NONE : CMD_SMP_RD;
            S_C_SMPW:  o_cmd = CMD_SMP_CAP;
            S_C_GEO:   o_cmd = CMD_GEO;
            S_C_TEST:  o_cmd = i_stat.skip ? CMD_SKIP : CMD_ROOT_GO;
            S_C_MUL:   o_cmd = CMD_MUL;
            S_C_DIVN:  o_cmd = CMD_NUM_GO;
            S_C_DIVNW: if (i_stat.div_done) o_cmd = CMD_NUM_ACC;
            S_C_DIVD:  o_cmd = CMD_DEN_GO;
            S_C_DIVDW: if (i_stat.div_done) o_cmd = CMD_DEN_ACC;
            S_C_FDIV:  o_cmd = CMD_FIN_GO;
            S_C_FDIVW: if (i_stat.div_done) o_cmd = CMD_FIN_ACC;
            S_C_FNEXT: o_cmd = CMD_FIN_UPD;
            S_C_WR:    o_cmd = CMD_SC_WR;
            S_C_OUT:   o_cmd = CMD_OUT_DONE;
            S_R_DIV:   o_cmd = CMD_RD_GO;
            S_R_DIVW:  if (i_stat.div_done) o_cmd = CMD_RD_ACC;
            S_R_NEXT:  o_cmd = CMD_RD_NEXT;
            S_R_OUT:   o_cmd = CMD_OUT_PIX;
            default:   o_cmd = CMD_NONE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* rtl/automatic_color_equalization_core.sv */
// Channel   | Direction | Handshake          | Beat
// ----------+-----------+--------------------+------------------------------
// in        | input     | valid / stall      | t_in: kind, coords, RGB
// out       | output    | valid / stall      | t_out: RGB scores, is_done
// cfg       | input     | write enable only  | index, 24-bit data
//
// Loads are taken in the idle state and do not stall intake. A read holds intake
// while the 64-step serial divider rescales each channel; a channel that rescales
// to 0 skips the divider. In a compute the divider runs four times per sample far
// enough to count and three times per pixel whose denominator is nonzero.
// Reset is synchronous, active low; memories hold undefined data until written.
// Intake stalls while an item is in work; a result waits in the output register.
// Depends on ace_pkg, ace_ctrl, ace_dp.
module automatic_color_equalization_core
    import ace_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    ace_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_data.kind),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    ace_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

endmodule

/* bench/ace_scoreboard.sv */
`timescale 1ns / 100ps
// Checker for the color equalization core: watches the input, output and register
// ports, keeps its own copy of the frame, sample and score stores, and compares
// results. Depends on ace_pkg.
module ace_scoreboard
    import ace_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in                  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out                 i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_results
);

    logic [23:0]   pix_mem [0:65535];
    int            score_mem [0:65535][0:2];
    logic [15:0]   smp_mem [0:255];
    int            ch_max [0:2];
    int            ch_min [0:2];
    int unsigned   smp_ptr;
    int unsigned   cfg_w, cfg_h, cfg_n, cfg_slope, cfg_limit;
    t_out          expected_q[$];

    // Digit-by-digit square root of d2, result in Q11.8
    function automatic longint root_q8(longint unsigned d2);
        longint unsigned v, res, b;
        v   = d2 << 16;
        res = 0;
        b   = 64'd1 << 34;
        for (int k = 0; k < 18; k++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // Score every active pixel and channel, tracking per-channel range
    task automatic score_frame();
        int unsigned w, h, n, t, sx, sy;
        longint t2, lim, dx, dy, d2, dq, p, sc, den;
        longint num [0:2];
        logic [23:0] pix, spix;
        w   = (cfg_w > 256) ? 256 : cfg_w;
        h   = (cfg_h > 256) ? 256 : cfg_h;
        n   = (cfg_n > 256) ? 256 : cfg_n;
        t   = h / 5;
        t2  = longint'(t) * t;
        lim = longint'(cfg_limit);
        for (int c = 0; c < 3; c++) begin
            ch_max[c] = 0;
            ch_min[c] = 32'h7FFF_FFFF;
        end
        for (int i = 0; i < w; i++) begin
            for (int j = 0; j < h; j++) begin
                num = '{0, 0, 0};
                den = 0;
                pix = pix_mem[j * 256 + i];
                for (int s = 0; s < n; s++) begin
                    sx = smp_mem[s][7:0];
                    sy = smp_mem[s][15:8];
                    if (sx > w - 1) sx = w - 1;
                    if (sy > h - 1) sy = h - 1;
                    dx = longint'(i) - longint'(sx);
                    dy = longint'(j) - longint'(sy);
                    d2 = dx * dx + dy * dy;
                    if (d2 < t2 || d2 == 0) continue;
                    dq   = root_q8(d2);
                    spix = pix_mem[sy * 256 + sx];
                    for (int c = 0; c < 3; c++) begin
                        p = (longint'(pix[8*c +: 8]) - longint'(spix[8*c +: 8]))
                            * longint'(cfg_slope);
                        if (p > lim) p = lim;
                        if (p < -lim) p = -lim;
                        num[c] += (p * 65536) / dq;
                    end
                    den += (lim * 65536) / dq;
                end
                for (int c = 0; c < 3; c++) begin
                    sc = (den > 0) ? (num[c] * 65536) / den : 0;
                    if (sc > 64'sd2147483647) sc = 64'sd2147483647;
                    if (sc < -64'sd2147483648) sc = -64'sd2147483648;
                    score_mem[j * 256 + i][c] = int'(sc);
                    if (int'(sc) > ch_max[c]) ch_max[c] = int'(sc);
                    if (int'(sc) < ch_min[c]) ch_min[c] = int'(sc);
                end
            end
        end
        smp_ptr = 0;
    endtask

    // Rescale the stored scores of one pixel to 0..255
    function automatic t_out rescale_pixel(int unsigned addr);
        t_out   r;
        longint v, lo, range, q;
        logic [7:0] col [0:2];
        for (int c = 0; c < 3; c++) begin
            q = 0;
            if (ch_max[c] > ch_min[c]) begin
                v     = score_mem[addr][c];
                lo    = ch_min[c];
                range = longint'(ch_max[c]) - lo;
                if (v > lo) q = ((v - lo) * 255) / range;
                if (q > 255) q = 255;
            end
            col[c] = q[7:0];
        end
        r.red_out   = col[0];
        r.green_out = col[1];
        r.blue_out  = col[2];
        r.is_done   = 1'b0;
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_out exp_beat;
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                ch_max[c] = 0;
                ch_min[c] = 32'h7FFF_FFFF;
            end
            smp_ptr   = 0;
            cfg_w     = 256;
            cfg_h     = 256;
            cfg_n     = 64;
            cfg_slope = 2560;
            cfg_limit = 256000;
            expected_q.delete();
            o_errors  = 0;
            o_results = 0;
        end else begin
            // Compare an accepted result beat with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected result beat %h", $realtime, i_out_data);
                end else begin
                    exp_beat = expected_q.pop_front();
                    if (i_out_data !== exp_beat) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: mismatch exp r=%0d g=%0d b=%0d done=%0b got r=%0d g=%0d b=%0d done=%0b",
                                $realtime, exp_beat.red_out, exp_beat.green_out,
                                exp_beat.blue_out, exp_beat.is_done, i_out_data.red_out,
                                i_out_data.green_out, i_out_data.blue_out, i_out_data.is_done);
                    end
                end
            end
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:   cfg_w     = i_cfg_data[8:0];
                    REG_HEIGHT:  cfg_h     = i_cfg_data[8:0];
                    REG_SAMPLES: cfg_n     = i_cfg_data[8:0];
                    REG_SLOPE:   cfg_slope = i_cfg_data[15:0];
                    REG_LIMIT:   cfg_limit = i_cfg_data[23:0];
                    default: ;
                endcase
            end
            // Predict the results of an accepted input beat
            if (i_in_valid && !i_in_stall) begin
                case (i_in_data.kind)
                    KIND_LD_SMP: begin
                        smp_mem[smp_ptr % 256] = {i_in_data.coord_y, i_in_data.coord_x};
                        smp_ptr = (smp_ptr + 1) % 256;
                    end
                    KIND_LD_PIX: begin
                        pix_mem[{i_in_data.coord_y, i_in_data.coord_x}] =
                            {i_in_data.blue_in, i_in_data.green_in, i_in_data.red_in};
                    end
                    KIND_COMPUTE: begin
                        score_frame();
                        expected_q.push_back('{8'd0, 8'd0, 8'd0, 1'b1});
                    end
                    default: begin
                        expected_q.push_back(
                            rescale_pixel({i_in_data.coord_y, i_in_data.coord_x}));
                    end
                endcase
            end
        end
    end

endmodule

/* bench/tb_automatic_color_equalization_core.sv */
`timescale 1ns / 100ps
// Testbench top for the color equalization core: drives loads, computes and reads
// over several register settings and idling modes; checking is in ace_scoreboard.
// Depends on ace_pkg, automatic_color_equalization_core, ace_scoreboard.
module tb_automatic_color_equalization_core;
    import ace_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in                  in_data;
    logic                 out_valid;
    logic                 out_stall;
    t_out                 out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   errors;
    int                   pending;
    int                   results;

    logic                 sender_idle;
    logic                 receiver_stall;
    bit                   scored [0:65535];
    int                   item_count;
    int                   compute_count;

    automatic_color_equalization_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ace_scoreboard scoreboard (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls at random in the stalling modes
    always @(posedge clk) begin
        out_stall <= receiver_stall ? ($urandom_range(99) < 72) : 1'b0;
    end

    // Hold a beat until accepted, idling first in the sender-idle modes
    task automatic send_beat(t_kind kind, logic [7:0] x, logic [7:0] y, logic [23:0] rgb);
        while (sender_idle && $urandom_range(99) < 72) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{kind, x, y, rgb[7:0], rgb[15:8], rgb[23:16]};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        item_count++;
        if (kind == KIND_COMPUTE) compute_count++;
    endtask

    // Drain all results, let the block settle, then write one register
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [23:0] rand_rgb();
        case ($urandom_range(3))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // One full pass: settings, samples, frame, compute, then reads mixed with loads
    task automatic run_pass(int w, int h, int n, int slope, int limit, int reads);
        int x, y;
        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
        write_reg(REG_SAMPLES, CFG_W'(n));
        write_reg(REG_SLOPE, CFG_W'(slope));
        write_reg(REG_LIMIT, CFG_W'(limit));
        for (int s = 0; s < n + $urandom_range(2); s++) begin
            if ($urandom_range(4) == 0)
                send_beat(KIND_LD_SMP, 8'($urandom), 8'($urandom), 24'($urandom));
            else
                send_beat(KIND_LD_SMP, 8'($urandom_range(w - 1)), 8'($urandom_range(h - 1)),
                          24'($urandom));
        end
        for (int i = 0; i < w; i++)
            for (int j = 0; j < h; j++)
                send_beat(KIND_LD_PIX, 8'(i), 8'(j), rand_rgb());
        send_beat(KIND_COMPUTE, 8'($urandom), 8'($urandom), 24'($urandom));
        for (int i = 0; i < w; i++)
            for (int j = 0; j < h; j++)
                scored[j * 256 + i] = 1'b1;
        for (int r = 0; r < reads; r++) begin
            if ($urandom_range(3) == 0) begin
                send_beat(KIND_LD_PIX, 8'($urandom), 8'($urandom), rand_rgb());
            end else begin
                // Read a pixel that some compute has scored
                do begin
                    x = $urandom_range(255);
                    y = $urandom_range(255);
                    if ($urandom_range(1) == 0) begin
                        x = $urandom_range(w - 1);
                        y = $urandom_range(h - 1);
                    end
                end while (!scored[y * 256 + x]);
                send_beat(KIND_READ, 8'(x), 8'(y), 24'($urandom));
            end
        end
    endtask

    initial begin
        int mode;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        sender_idle    = 1'b0;
        receiver_stall = 1'b0;
        item_count     = 0;
        compute_count  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 3x3 frame, extreme slope and limit, saturated and self samples
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 3);
        write_reg(REG_SAMPLES, 4);
        write_reg(REG_SLOPE, 16'hFFFF);
        write_reg(REG_LIMIT, 24'hFFFFFF);
        send_beat(KIND_LD_SMP, 8'd255, 8'd255, 24'h0);
        send_beat(KIND_LD_SMP, 8'd0, 8'd0, 24'h0);
        send_beat(KIND_LD_SMP, 8'd1, 8'd2, 24'h0);
        send_beat(KIND_LD_SMP, 8'd2, 8'd255, 24'h0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                send_beat(KIND_LD_PIX, 8'(i), 8'(j), (i + j) % 2 ? 24'hFFFFFF : 24'h000000);
        send_beat(KIND_LD_PIX, 8'd255, 8'd255, 24'h123456);
        send_beat(KIND_COMPUTE, 8'd0, 8'd0, 24'h0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                scored[j * 256 + i] = 1'b1;
        send_beat(KIND_READ, 8'd0, 8'd0, 24'h0);
        send_beat(KIND_READ, 8'd1, 8'd1, 24'h0);
        send_beat(KIND_READ, 8'd2, 8'd2, 24'h0);
        send_beat(KIND_READ, 8'd1, 8'd0, 24'h0);

        // Random passes, cycling through the idling modes
        for (int p = 0; item_count < 1150; p++) begin
            mode           = p % 4;
            sender_idle    = (mode == 1 || mode == 3);
            receiver_stall = (mode == 2 || mode == 3);
            case (p)
                1: run_pass(256, 1, 1, 0, 1, 30);
                2: run_pass(1, 256, 2, 16'hFFFF, 1, 30);
                3: run_pass(1, 1, 256, $urandom_range(65535), 24'hFFFFFF, 10);
                default: run_pass($urandom_range(1, 4), $urandom_range(1, 6),
                                  $urandom_range(1, 8),
                                  ($urandom_range(3) == 0) ? 65535 : $urandom_range(4096),
                                  ($urandom_range(3) == 0) ? $urandom_range(1, 16777215)
                                                           : $urandom_range(1, 100000),
                                  50);
            endcase
        end

        // Drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Covered %0d input beats, %0d computes, %0d result beats checked.",
                 item_count, compute_count, results);
        $display("Idling modes: none, sender idle, receiver stall, both; %0d mismatches.",
                 errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Overall time limit
    initial begin
        #200_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
